[hw/rtl/ssw_pkg.sv]
package ssw_pkg;

  // Letters arrive as a 5-bit index, a=0 through z=25.
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned ALPHA = 26;
  localparam logic [LETTER_W-1:0] LETTER_MAX = 5'd25;

  // Kind of an input word, carried on tuser.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef logic [LETTER_W-1:0] letter_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_LONG = 2'd2
  } status_e;

  // Write strobes for the trie tables.
  typedef struct packed {
    logic link_we;
    logic mark_we;
    logic mark_val;
  } trie_wr_t;

  // Control of the letter history.
  typedef struct packed {
    logic push;
    letter_t letter;
    logic step;
  } hist_ctl_t;

  // Codes above z are saturated to z.
  function automatic letter_t clamp_letter(letter_t v);
    return (v > LETTER_MAX) ? LETTER_MAX : v;
  endfunction

endpackage

[hw/rtl/ssw_trie.sv]
module ssw_trie #(
  parameter int unsigned NODES = 1024
) (
  input  logic                     clk_i,
  input  logic [$clog2(NODES)-1:0] rd_node_i,
  input  ssw_pkg::letter_t         rd_letter_i,
  output logic [$clog2(NODES)-1:0] link_rd_o,
  output logic                     mark_rd_o,
  input  ssw_pkg::trie_wr_t        wr_i,
  input  logic [$clog2(NODES)-1:0] wr_node_i,
  input  ssw_pkg::letter_t         wr_letter_i,
  input  logic [$clog2(NODES)-1:0] wr_link_i,
  input  logic [$clog2(NODES)-1:0] mark_node_i
);
  import ssw_pkg::*;

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned SLOTS = NODES * ALPHA;
  localparam int unsigned AW = $clog2(SLOTS);

  logic [NW-1:0] link_mem [SLOTS];
  logic          mark_mem [NODES];

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;

  // One row of ALPHA child links per node.
  function automatic logic [AW-1:0] slot_addr(logic [NW-1:0] node, letter_t ltr);
    return AW'(node) * AW'(ALPHA) + AW'(ltr);
  endfunction

  assign rd_addr = slot_addr(rd_node_i, rd_letter_i);
  assign wr_addr = slot_addr(wr_node_i, wr_letter_i);

  always_ff @(posedge clk_i) begin
    if (wr_i.link_we) begin
      link_mem[wr_addr] <= wr_link_i;
    end
    link_rd_o <= link_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.mark_we) begin
      mark_mem[mark_node_i] <= wr_i.mark_val;
    end
    mark_rd_o <= mark_mem[rd_node_i];
  end

endmodule

[hw/rtl/ssw_hist.sv]
module ssw_hist #(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ssw_pkg::hist_ctl_t ctl_i,
  output ssw_pkg::letter_t   letter_o
);
  import ssw_pkg::*;

  localparam int unsigned PW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  letter_t       mem [MAX_LEN];
  logic [PW-1:0] wp_q, wp_d;
  logic [PW-1:0] rp_q, rp_d;
  logic [PW-1:0] rd_addr;

  function automatic logic [PW-1:0] ptr_dec(logic [PW-1:0] p);
    return (p == '0) ? PW'(MAX_LEN - 1) : p - 1'b1;
  endfunction

  function automatic logic [PW-1:0] ptr_inc(logic [PW-1:0] p);
    return (p == PW'(MAX_LEN - 1)) ? '0 : p + 1'b1;
  endfunction

  // A push reads the entry behind the new letter, so the walk has its
  // second letter in the cycle after; each step then reads one entry older.
  always_comb begin
    wp_d = wp_q;
    rp_d = rp_q;
    rd_addr = rp_q;
    if (ctl_i.push) begin
      wp_d = ptr_inc(wp_q);
      rp_d = ptr_dec(ptr_dec(wp_q));
      rd_addr = ptr_dec(wp_q);
    end else if (ctl_i.step) begin
      rp_d = ptr_dec(rp_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[wp_q] <= ctl_i.letter;
    end
    letter_o <= mem[rd_addr];
  end

endmodule

[hw/rtl/stream_suffix_word_matcher.sv]
// Insert word: S_INS_RD, S_INS_WR, then S_DONE until the output register is free.
// Query word: S_QRY_PUSH, then S_WALK visits one trie level per step, as the link table has a
// single read port, then S_DONE. A new word is taken only after the result is loaded.
// After reset a clearing pass writes every trie entry, one a cycle, with s_axis_tready low.
// The letter history needs no clearing.
module stream_suffix_word_matcher #(
  parameter int unsigned NODES = 1024,
  parameter int unsigned MAX_LEN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [4:0] letter, [7:5] zero
  input  logic       s_axis_tlast,  // word_last
  input  logic [0:0] s_axis_tuser,  // [0] action
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // [0] match, [2:1] status, [7:3] zero
);
  import ssw_pkg::*;

  localparam int unsigned NW = $clog2(NODES);
  localparam int unsigned FW = $clog2(NODES + 1);
  localparam int unsigned DW = $clog2(MAX_LEN + 1);

  // The sequencer. A query pushes its letter, then walks the trie from the
  // root one level a cycle; the link and mark tables are the shared lookup
  // unit that every insert step and every walk step goes through.
  typedef enum logic [6:0] {
    S_CLR      = 7'b0000001,
    S_IDLE     = 7'b0000010,
    S_INS_RD   = 7'b0000100,
    S_INS_WR   = 7'b0001000,
    S_QRY_PUSH = 7'b0010000,
    S_WALK     = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_e;

  state_e        state_q, state_d;
  logic [NW-1:0] clr_node_q, clr_node_d;
  letter_t       clr_let_q, clr_let_d;
  logic [FW-1:0] free_q, free_d;
  logic [NW-1:0] cur_q, cur_d;
  logic [DW-1:0] depth_q, depth_d;
  status_e       fault_q, fault_d;
  logic [DW-1:0] longest_q, longest_d;
  logic [DW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] lvl_q, lvl_d;
  logic          final_q, final_d;
  logic          m_valid_q, m_valid_d;

  // Payload registers.
  letter_t       let_q;
  logic          last_q;
  logic          match_q;
  status_e       status_q;
  logic          m_match_q;
  status_e       m_status_q;

  logic          s_accept;
  logic          out_load;

  // Lookup unit ports.
  logic [NW-1:0] rd_node;
  letter_t       rd_let;
  logic [NW-1:0] link_rd;
  logic          mark_rd;
  trie_wr_t      trie_wr;
  logic [NW-1:0] wr_node;
  letter_t       wr_let;
  logic [NW-1:0] wr_link;
  logic [NW-1:0] mark_node;

  hist_ctl_t     hist_ctl;
  letter_t       hist_rd;

  // Insert step.
  status_e       ins_fault;
  logic [NW-1:0] ins_cur;
  logic [DW-1:0] ins_depth;
  logic          ins_alloc;
  logic          word_done;

  // Query step.
  logic [DW:0]   cnt_inc;
  logic [DW-1:0] cnt_nx;
  logic [DW:0]   lvl_inc;
  logic          walk_end;
  logic          next_final;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata = {5'b0, m_status_q, m_match_q};

  // The output register frees the sequencer as soon as the result is parked.
  assign out_load = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

  ssw_trie #(
    .NODES(NODES)
  ) u_trie (
    .clk_i       (clk_i),
    .rd_node_i   (rd_node),
    .rd_letter_i (rd_let),
    .link_rd_o   (link_rd),
    .mark_rd_o   (mark_rd),
    .wr_i        (trie_wr),
    .wr_node_i   (wr_node),
    .wr_letter_i (wr_let),
    .wr_link_i   (wr_link),
    .mark_node_i (mark_node)
  );

  ssw_hist #(
    .MAX_LEN(MAX_LEN)
  ) u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (hist_ctl),
    .letter_o (hist_rd)
  );

  // An insert letter follows the existing child, takes the next free node, or faults
  // (ST_LONG, ST_FULL). Once a word has faulted its remaining letters change nothing.
  always_comb begin
    ins_fault = fault_q;
    ins_cur = cur_q;
    ins_depth = depth_q;
    ins_alloc = 1'b0;
    if (fault_q == ST_OK) begin
      if (depth_q >= DW'(MAX_LEN)) begin
        ins_fault = ST_LONG;
      end else begin
        ins_cur = link_rd;
        if (link_rd == '0) begin
          if (free_q >= FW'(NODES)) begin
            ins_fault = ST_FULL;
            ins_cur = cur_q;
          end else begin
            ins_alloc = 1'b1;
            ins_cur = free_q[NW-1:0];
          end
        end
        if (ins_fault == ST_OK) begin
          ins_depth = depth_q + DW'(1);
        end
      end
    end
    word_done = last_q && (ins_fault == ST_OK);
  end

  // The history keeps no more letters than the longest stored word.
  // A walk ends on a marked node, a missing child, or after the final mark
  // check; in each case the answer is the mark that was just read.
  always_comb begin
    cnt_inc = {1'b0, cnt_q} + (DW + 1)'(1);
    cnt_nx = (cnt_inc > {1'b0, longest_q}) ? longest_q : cnt_inc[DW-1:0];
    lvl_inc = {1'b0, lvl_q} + (DW + 1)'(1);
    next_final = (lvl_inc >= {1'b0, cnt_q});
    walk_end = final_q || mark_rd || (link_rd == '0);
  end

  // Lookup address: the newest letter is taken from the captured input letter register,
  // older ones come from the registered read output of the history.
  always_comb begin
    case (state_q)
      S_QRY_PUSH: begin
        rd_node = '0;
        rd_let = let_q;
      end
      S_WALK: begin
        rd_node = link_rd;
        rd_let = hist_rd;
      end
      default: begin
        rd_node = cur_q;
        rd_let = let_q;
      end
    endcase
  end

  always_comb begin
    trie_wr = '0;
    wr_node = cur_q;
    wr_let = let_q;
    wr_link = free_q[NW-1:0];
    mark_node = ins_cur;
    case (state_q)
      S_CLR: begin
        trie_wr.link_we = 1'b1;
        trie_wr.mark_we = 1'b1;
        trie_wr.mark_val = 1'b0;
        wr_node = clr_node_q;
        wr_let = clr_let_q;
        wr_link = '0;
        mark_node = clr_node_q;
      end
      S_INS_WR: begin
        trie_wr.link_we = ins_alloc;
        trie_wr.mark_we = word_done;
        trie_wr.mark_val = 1'b1;
      end
      default: begin
        trie_wr = '0;
      end
    endcase
  end

  always_comb begin
    hist_ctl.push = (state_q == S_QRY_PUSH);
    hist_ctl.letter = let_q;
    hist_ctl.step = (state_q == S_WALK) && !walk_end;
  end

  always_comb begin
    state_d = state_q;
    clr_node_d = clr_node_q;
    clr_let_d = clr_let_q;
    free_d = free_q;
    cur_d = cur_q;
    depth_d = depth_q;
    fault_d = fault_q;
    longest_d = longest_q;
    cnt_d = cnt_q;
    lvl_d = lvl_q;
    final_d = final_q;
    m_valid_d = m_valid_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    case (state_q)
      S_CLR: begin
        if (clr_let_q == LETTER_MAX) begin
          clr_let_d = '0;
          clr_node_d = clr_node_q + 1'b1;
          if (clr_node_q == NW'(NODES - 1)) begin
            state_d = S_IDLE;
          end
        end else begin
          clr_let_d = clr_let_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (s_accept) begin
          state_d = (s_axis_tuser[0] == ACT_INSERT) ? S_INS_RD : S_QRY_PUSH;
        end
      end
      S_INS_RD: begin
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        free_d = free_q + FW'(ins_alloc);
        if (last_q) begin
          cur_d = '0;
          depth_d = '0;
          fault_d = ST_OK;
          if (word_done && (ins_depth > longest_q)) begin
            longest_d = ins_depth;
          end
        end else begin
          cur_d = ins_cur;
          depth_d = ins_depth;
          fault_d = ins_fault;
        end
        state_d = S_DONE;
      end
      S_QRY_PUSH: begin
        cnt_d = cnt_nx;
        lvl_d = '0;
        final_d = (cnt_nx == '0);
        state_d = S_WALK;
      end
      S_WALK: begin
        if (walk_end) begin
          state_d = S_DONE;
        end else begin
          lvl_d = lvl_inc[DW-1:0];
          final_d = next_final;
        end
      end
      S_DONE: begin
        if (out_load) begin
          m_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_node_q <= '0;
      clr_let_q <= '0;
      free_q <= FW'(1);
      cur_q <= '0;
      depth_q <= '0;
      fault_q <= ST_OK;
      longest_q <= '0;
      cnt_q <= '0;
      lvl_q <= '0;
      final_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_node_q <= clr_node_d;
      clr_let_q <= clr_let_d;
      free_q <= free_d;
      cur_q <= cur_d;
      depth_q <= depth_d;
      fault_q <= fault_d;
      longest_q <= longest_d;
      cnt_q <= cnt_d;
      lvl_q <= lvl_d;
      final_q <= final_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      let_q <= clamp_letter(s_axis_tdata[LETTER_W-1:0]);
      last_q <= s_axis_tlast;
    end
    if (state_q == S_INS_WR) begin
      match_q <= 1'b0;
      status_q <= ins_fault;
    end
    if ((state_q == S_WALK) && walk_end) begin
      match_q <= mark_rd;
      status_q <= ST_OK;
    end
    if (out_load) begin
      m_match_q <= match_q;
      m_status_q <= status_q;
    end
  end

`ifndef ASSERT_OFF
  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q >= FW'(1)) && (free_q <= FW'(NODES)))
    else $error("free node counter out of range");

  a_hist_trim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= longest_q)
    else $error("history holds more letters than the longest word");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(MAX_LEN))
    else $error("insert depth beyond MAX_LEN");

  a_walk_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_WALK) && !final_q) |-> (lvl_q < cnt_q))
    else $error("walk level beyond history");

  a_result_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (m_axis_tvalid && (state_q == S_IDLE)))
    else $error("finished word not presented");
`endif

endmodule
